// File: design/assert_macros.svh
// Assertion macros used by the frame core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/sldf_pkg.sv
// Types and constants for the sync, length and XOR checksum packet deframer.
package sldf_pkg;

  localparam int unsigned FRAME_POS_W = 11;
  localparam int unsigned LEN_W       = 16;

  localparam logic [7:0] CHECKSUM_SEED = 8'hA5;
  localparam logic [2:0] HEADER_LAST   = 3'd3;

  localparam logic [1:0] POS_SYNC0 = 2'd0;
  localparam logic [1:0] POS_SYNC1 = 2'd1;
  localparam logic [1:0] POS_LENHI = 2'd2;
  localparam logic [1:0] POS_LENLO = 2'd3;

  localparam logic CFG_FIRST_SYNC  = 1'b0;
  localparam logic CFG_SECOND_SYNC = 1'b1;

  typedef struct packed {
    logic [7:0]             echo_byte;
    logic [FRAME_POS_W-1:0] frame_position;
    logic                   sync_discard;
    logic                   frame_last;
    logic                   checksum_good;
    logic                   length_bad;
  } sldf_result_t;

endpackage

// File: design/sync_length_xor_packet_deframer.sv
// Top level of the sync, length and XOR checksum packet deframer.
// Usage:
// Bytes of the received stream enter on the in_ channel, one per transaction.
// Every byte leaves on the out_ channel exactly once, in order, with its
// offset in the frame and status flags: a failed sync check, a bad length,
// the last byte of a frame and, on that byte, whether the checksum matched.
// A frame is two sync bytes, a big-endian 16-bit length L and L more bytes,
// the last of which is the XOR of the ones before it seeded with 0xA5.
// A byte accepted is offered on the out_ channel from the next cycle.
// Throughput is one byte per cycle, set by the single result register,
// which takes a new byte whenever it is empty or its contents are being
// taken in the same cycle.
// When the receiver stalls, the result register holds its transaction and
// in_stall rises in the same cycle, so nothing is lost.
// The user must write the sync values on the cfg_ port only while the block
// is idle; the block itself does not enforce it. After reset the block hunts
// for the first sync byte, both sync values are zero and the result register is empty.
module sync_length_xor_packet_deframer
  import sldf_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD_LENGTH = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_index,
  input  logic [7:0]             cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_rx_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_echo_byte,
  output logic [FRAME_POS_W-1:0] out_frame_position,
  output logic                   out_sync_discard,
  output logic                   out_frame_last,
  output logic                   out_checksum_good,
  output logic                   out_length_bad
);

  logic [7:0]   first_sync_r;
  logic [7:0]   second_sync_r;
  logic         out_valid_r, out_valid_nxt;
  sldf_result_t out_res_r;
  sldf_result_t result;
  logic         in_accept;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign out_valid_nxt = in_accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_sync_r  <= '0;
      second_sync_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FIRST_SYNC:  first_sync_r  <= cfg_wdata;
        CFG_SECOND_SYNC: second_sync_r <= cfg_wdata;
        default:         first_sync_r  <= first_sync_r;
      endcase
    end
  end

  sldf_frame_core #(
    .MAX_PAYLOAD_LENGTH(MAX_PAYLOAD_LENGTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .rx_byte    (in_rx_byte),
    .first_sync (first_sync_r),
    .second_sync(second_sync_r),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_res_r <= result;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_echo_byte      = out_res_r.echo_byte;
  assign out_frame_position = out_res_r.frame_position;
  assign out_sync_discard   = out_res_r.sync_discard;
  assign out_frame_last     = out_res_r.frame_last;
  assign out_checksum_good  = out_res_r.checksum_good;
  assign out_length_bad     = out_res_r.length_bad;

endmodule

// File: design/sldf_frame_core.sv
// Frame tracking state and per-byte result generation of the deframer.
`include "assert_macros.svh"

module sldf_frame_core
  import sldf_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD_LENGTH = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         accept,
  input  logic [7:0]   rx_byte,
  input  logic [7:0]   first_sync,
  input  logic [7:0]   second_sync,
  output sldf_result_t result
);

  localparam int unsigned POS_W  = $clog2(MAX_PAYLOAD_LENGTH + 4);
  localparam int unsigned WIDE_W = (POS_W > FRAME_POS_W) ? POS_W : FRAME_POS_W;
  localparam logic [LEN_W:0] MaxLen = (LEN_W + 1)'(MAX_PAYLOAD_LENGTH);
  localparam logic [LEN_W:0] MinLen = (LEN_W + 1)'(2);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  last_pos_r, last_pos_nxt;
  logic [7:0]        xor_r, xor_nxt;
  logic [7:0]        len_hi_r, len_hi_nxt;
  logic [WIDE_W-1:0] pos_wide;
  logic [LEN_W:0]    len_ext;
  logic [LEN_W:0]    last_sum;

  assign pos_wide = WIDE_W'(pos_r);
  assign len_ext  = (LEN_W + 1)'({len_hi_r, rx_byte});
  assign last_sum = len_ext + (LEN_W + 1)'(HEADER_LAST);

  always_comb begin
    pos_nxt      = pos_r;
    last_pos_nxt = last_pos_r;
    xor_nxt      = xor_r;
    len_hi_nxt   = len_hi_r;

    result                = '0;
    result.echo_byte      = rx_byte;
    result.frame_position = pos_wide[FRAME_POS_W-1:0];

    if (pos_r == POS_W'(POS_SYNC0)) begin
      if (rx_byte != first_sync) begin
        result.sync_discard = 1'b1;
      end else begin
        xor_nxt = CHECKSUM_SEED;
        pos_nxt = POS_W'(POS_SYNC1);
      end
    end else if (pos_r == POS_W'(POS_SYNC1)) begin
      if (rx_byte != second_sync) begin
        result.sync_discard = 1'b1;
        pos_nxt      = '0;
        last_pos_nxt = '0;
        xor_nxt      = CHECKSUM_SEED;
        len_hi_nxt   = '0;
      end else begin
        pos_nxt = POS_W'(POS_LENHI);
      end
    end else if (pos_r == POS_W'(POS_LENHI)) begin
      len_hi_nxt = rx_byte;
      pos_nxt    = POS_W'(POS_LENLO);
    end else if (pos_r == POS_W'(POS_LENLO)) begin
      if ((len_ext < MinLen) || (len_ext > MaxLen)) begin
        result.length_bad = 1'b1;
        pos_nxt      = '0;
        last_pos_nxt = '0;
        xor_nxt      = CHECKSUM_SEED;
        len_hi_nxt   = '0;
      end else begin
        last_pos_nxt = POS_W'(last_sum);
        pos_nxt      = pos_r + POS_W'(1);
      end
    end else begin
      if (pos_r >= last_pos_r) begin
        result.frame_last    = 1'b1;
        result.checksum_good = (rx_byte == xor_r);
        pos_nxt      = '0;
        last_pos_nxt = '0;
        xor_nxt      = CHECKSUM_SEED;
        len_hi_nxt   = '0;
      end else begin
        xor_nxt = xor_r ^ rx_byte;
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      last_pos_r <= '0;
      xor_r      <= CHECKSUM_SEED;
      len_hi_r   <= '0;
    end else if (accept) begin
      pos_r      <= pos_nxt;
      last_pos_r <= last_pos_nxt;
      xor_r      <= xor_nxt;
      len_hi_r   <= len_hi_nxt;
    end
  end

  `ASSERT_CLK(a_pos_within_frame,
    (pos_r > POS_W'(POS_LENLO)) |-> (pos_r <= last_pos_r),
    "payload position ran past the end of the frame")
  `ASSERT_CLK(a_hunt_after_last,
    (accept && result.frame_last) |=> (pos_r == '0 && xor_r == CHECKSUM_SEED),
    "hunting did not restart after the last byte of a frame")
  `ASSERT_CLK(a_flags_exclusive,
    accept |-> ($countones({result.sync_discard, result.frame_last,
                            result.length_bad}) <= 1),
    "more than one status flag raised for a byte")
  `ASSERT_ALWAYS(a_good_only_on_last,
    result.checksum_good |-> result.frame_last,
    "checksum good raised on a byte that is not the last")

endmodule
